@@ rtl/core/utf8d_pkg.sv @@
// Shared types and constants for the streaming UTF-8 byte decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StMalformed = 2'd1;
  localparam logic [1:0] StAbort     = 2'd2;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

  typedef struct packed {
    logic [1:0]         pending;
    logic [CpWidth-1:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic               valid;
    logic [CpWidth-1:0] code_point;
    logic [1:0]         status;
    logic               string_end;
  } dec_result_t;

endpackage

@@ rtl/core/utf8d_in_if.sv @@
// Input channel: one raw string byte and its last-byte flag.
`timescale 1ns / 1ps

interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last_byte;

  modport source (output valid, output data_byte, output is_last_byte, input ready);
  modport sink (input valid, input data_byte, input is_last_byte, output ready);
endinterface

@@ rtl/core/utf8d_out_if.sv @@
// Output channel: one decoded code point with its status and end flag.
`timescale 1ns / 1ps

interface utf8d_out_if
  import utf8d_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CpWidth-1:0] code_point;
  logic [1:0]         status;
  logic               string_end;

  modport source (output valid, output code_point, output status, output string_end,
                  input ready);
  modport sink (input valid, input code_point, input status, input string_end,
                output ready);
endinterface

@@ rtl/core/utf8d_step.sv @@
// Next-state and result logic for one byte of the UTF-8 decoder.
`timescale 1ns / 1ps

module utf8d_step
  import utf8d_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_byte_i,
  output dec_state_t  state_o,
  output dec_result_t result_o
);

  logic               is_cont;
  logic [1:0]         pend_dec;
  logic [CpWidth-1:0] payload;
  logic [CpWidth-1:0] merged;

  assign is_cont  = (data_byte_i[7:6] == 2'b10);
  assign pend_dec = state_i.pending - 2'd1;

  always_comb begin
    case (pend_dec)
      2'd0:    payload = {15'd0, data_byte_i[5:0]};
      2'd1:    payload = {9'd0, data_byte_i[5:0], 6'd0};
      2'd2:    payload = {3'd0, data_byte_i[5:0], 12'd0};
      default: payload = {data_byte_i[2:0], 18'd0};
    endcase
  end

  assign merged = state_i.partial | payload;

  always_comb begin
    state_o             = state_i;
    result_o.valid      = 1'b0;
    result_o.code_point = '0;
    result_o.status     = StOk;
    result_o.string_end = is_last_byte_i;

    if (state_i.pending == 2'd0) begin
      if (!data_byte_i[7]) begin
        result_o.valid      = 1'b1;
        result_o.code_point = {13'd0, data_byte_i};
      end else if (is_cont || data_byte_i[7:3] == 5'b11111) begin
        result_o.valid  = 1'b1;
        result_o.status = StAbort;
      end else if (is_last_byte_i) begin
        result_o.valid  = 1'b1;
        result_o.status = StAbort;
      end else if (data_byte_i[7:5] == 3'b110) begin
        state_o.pending = 2'd1;
        state_o.partial = {10'd0, data_byte_i[4:0], 6'd0};
      end else if (data_byte_i[7:4] == 4'b1110) begin
        state_o.pending = 2'd2;
        state_o.partial = {5'd0, data_byte_i[3:0], 12'd0};
      end else begin
        state_o.pending = 2'd3;
        state_o.partial = {data_byte_i[2:0], 18'd0};
      end
    end else if (!is_cont) begin
      result_o.valid      = 1'b1;
      result_o.code_point = Replacement;
      result_o.status     = StMalformed;
    end else if (pend_dec == 2'd0) begin
      result_o.valid      = 1'b1;
      result_o.code_point = merged;
    end else if (is_last_byte_i) begin
      result_o.valid  = 1'b1;
      result_o.status = StAbort;
    end else begin
      state_o.pending = pend_dec;
      state_o.partial = merged;
    end

    if (result_o.valid) begin
      state_o = '0;
    end
  end

endmodule

@@ rtl/core/utf8_byte_decoder.sv @@
// Top level of the streaming UTF-8 byte decoder.
//
//   Channel  Dir  Payload                                 Handshake
//   in_i     in   data_byte[7:0], is_last_byte            valid / ready
//   out_o    out  code_point[20:0], status[1:0], string_end  valid / ready
//
// One byte is taken per clock unless a held result is not taken; results
// are registered. The decode is a single combinational pass from the
// sequence state and the incoming byte into the result register.
// Reset clears the sequence state and the result valid flag.
// While a result is held and not taken, no byte is accepted; the slot frees
// in the same cycle the result leaves, so full rate holds without stalls.
`timescale 1ns / 1ps

module utf8_byte_decoder
  import utf8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  utf8d_in_if.sink   in_i,
  utf8d_out_if.source out_o
);

  dec_state_t  state_q, state_d;
  dec_result_t res_step;
  logic        out_valid_q;
  logic [CpWidth-1:0] cp_q;
  logic [1:0]  status_q;
  logic        end_q;
  logic        accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  utf8d_step u_step (
    .state_i        (state_q),
    .data_byte_i    (in_i.data_byte),
    .is_last_byte_i (in_i.is_last_byte),
    .state_o        (state_d),
    .result_o       (res_step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= res_step.valid;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_step.valid) begin
      cp_q     <= res_step.code_point;
      status_q <= res_step.status;
      end_q    <= res_step.string_end;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_point = cp_q;
  assign out_o.status     = status_q;
  assign out_o.string_end = end_q;

endmodule

@@ verif/utf8_decode_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts every decoded character of utf8_byte_decoder and compares it.
module utf8_decode_checker
  import utf8d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [CpWidth-1:0] out_code_point_i,
  input  logic [1:0]         out_status_i,
  input  logic               out_string_end_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        outstanding_o
);

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic [1:0]         status;
    logic               string_end;
  } char_result_t;

  char_result_t       expected_chars[$];
  logic [1:0]         cont_left;
  logic [CpWidth-1:0] code_acc;
  int unsigned        mismatches;

  task automatic close_char(input logic [CpWidth-1:0] cp, input logic [1:0] st,
                            input logic last);
    char_result_t res;
    res.code_point = cp;
    res.status     = st;
    res.string_end = last;
    expected_chars = {expected_chars, res};
    cont_left = 2'd0;
    code_acc  = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic is_cont;
    is_cont = (b[7:6] == 2'b10);
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        close_char(CpWidth'(b), StOk, last);
        return;
      end
      if (b[7:5] == 3'b110) begin
        code_acc  = CpWidth'(b[4:0]) << 6;
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        code_acc  = CpWidth'(b[3:0]) << 12;
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        code_acc  = CpWidth'(b[2:0]) << 18;
        cont_left = 2'd3;
      end else begin
        // Stray continuation bytes and F8..FF both abort.
        close_char('0, StAbort, last);
        return;
      end
      if (last) close_char('0, StAbort, last);
      return;
    end
    if (!is_cont) begin
      close_char(Replacement, StMalformed, last);
      return;
    end
    cont_left = cont_left - 2'd1;
    code_acc  = code_acc | (CpWidth'(b[5:0]) << (6 * cont_left));
    if (cont_left == 2'd0) close_char(code_acc, StOk, last);
    else if (last) close_char('0, StAbort, last);
  endtask

  task automatic check_char();
    char_result_t want;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t: unexpected result code_point %h status %0d string_end %0d", $realtime,
                 out_code_point_i, out_status_i, out_string_end_i);
      return;
    end
    want = expected_chars.pop_front();
    if (out_code_point_i !== want.code_point || out_status_i !== want.status ||
        out_string_end_i !== want.string_end) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t: expected code_point %h status %0d string_end %0d, got %h %0d %0d",
                 $realtime, want.code_point, want.status, want.string_end,
                 out_code_point_i, out_status_i, out_string_end_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      cont_left        = 2'd0;
      code_acc         = '0;
      mismatches       = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_char();
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i, in_last_i);
      mismatch_count_o <= mismatches;
      outstanding_o    <= unsigned'(expected_chars.size());
    end
  end

endmodule

@@ verif/tb_utf8_byte_decoder.sv @@
`timescale 1ns / 1ps
// Testbench top for utf8_byte_decoder: clock, reset, byte stimulus, output stalls and verdict.
module tb_utf8_byte_decoder;
  import utf8d_pkg::*;

  localparam int RandomBytes   = 450;
  localparam int HoldOffAt     = 120;
  localparam int HoldOffCycles = 400;
  localparam int DirectedCount = 24;

  // Each entry is {last flag, byte}.
  localparam logic [8:0] DirectedBytes [DirectedCount] = '{
    9'h000, 9'h17F,
    9'h0C0, 9'h080,
    9'h0EF, 9'h0BF, 9'h1BF,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h080, 9'h0FF, 9'h1F8,
    9'h0DF, 9'h041,
    9'h0E0, 9'h0F0,
    9'h1C3,
    9'h0F0, 9'h090, 9'h180,
    9'h0E2, 9'h1FF
  };

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned outstanding;
  bit          send_calm;
  bit          take_calm;
  int          random_sent;
  int          send_gap;
  int          take_stall;
  int unsigned taken;
  logic [7:0]  string_bytes[$];
  bit          noisy_string;

  utf8d_in_if  in_ch ();
  utf8d_out_if out_ch ();

  utf8_byte_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  utf8_decode_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_byte_i        (in_ch.data_byte),
    .in_last_i        (in_ch.is_last_byte),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_code_point_i (out_ch.code_point),
    .out_status_i     (out_ch.status),
    .out_string_end_i (out_ch.string_end),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Alternates between calm stretches with no waiting and busy ones.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  task automatic add_byte(input logic [7:0] b);
    string_bytes = {string_bytes, b};
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    send_gap = draw_wait(send_calm);
    if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (send_gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.is_last_byte <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic build_string();
    int nchars;
    int len;
    int ncont;
    int kind;
    string_bytes.delete();
    nchars       = $urandom_range(1, 8);
    noisy_string = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < nchars; i++) begin
      if (noisy_string) begin
        add_byte(8'($urandom));
      end else begin
        len  = $urandom_range(1, 4);
        kind = $urandom_range(0, 9);
        case (len)
          1: add_byte({1'b0, 7'($urandom)});
          2: add_byte({3'b110, 5'($urandom)});
          3: add_byte({4'b1110, 4'($urandom)});
          default: add_byte({5'b11110, 3'($urandom)});
        endcase
        ncont = len - 1;
        if (kind == 0 && ncont > 0) ncont = $urandom_range(0, ncont - 1);
        repeat (ncont) add_byte({2'b10, 6'($urandom)});
        if (kind == 1) add_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.is_last_byte = 1'b0;
    send_calm          = 1'b0;
    random_sent        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedCount; i++)
      send_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);

    while (random_sent < RandomBytes) begin
      build_string();
      for (int i = 0; i < string_bytes.size(); i++) begin
        send_byte(string_bytes[i], (i == string_bytes.size() - 1) ||
                  (noisy_string && $urandom_range(0, 7) == 0));
        random_sent++;
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("utf8_byte_decoder: match");
    end else begin
      $display("utf8_byte_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    take_calm    = 1'b0;
    taken        = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      take_stall = (taken == HoldOffAt) ? HoldOffCycles : draw_wait(take_calm);
      if (take_stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (take_stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    #2_000_000;
    $display("utf8_byte_decoder: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_in_if.sv
rtl/core/utf8d_out_if.sv
rtl/core/utf8d_step.sv
rtl/core/utf8_byte_decoder.sv
verif/utf8_decode_checker.sv
verif/tb_utf8_byte_decoder.sv
